### design/becm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes of the bus echo collision monitor.
package becm_pkg;

    localparam int MAX_BYTES = 32;
    localparam int AW        = $clog2(MAX_BYTES);
    localparam int CW        = $clog2(MAX_BYTES + 1);
    localparam int TW        = 16;
    localparam int DW        = 8;
    localparam int PAW       = 3;
    localparam int PDW       = 32;

    typedef logic [1:0]    t_cmd;
    typedef logic [DW-1:0] t_byte;
    typedef logic [2:0]    t_kind;
    typedef logic [CW-1:0] t_count;
    typedef logic [TW-1:0] t_ticks;

    localparam t_cmd CMD_LOAD = 2'd0;
    localparam t_cmd CMD_ARM  = 2'd1;
    localparam t_cmd CMD_RX   = 2'd2;
    localparam t_cmd CMD_TICK = 2'd3;

    localparam t_kind K_ACCEPTED  = 3'd0;
    localparam t_kind K_BUSY      = 3'd1;
    localparam t_kind K_RXBYTE    = 3'd2;
    localparam t_kind K_CONFIRMED = 3'd3;
    localparam t_kind K_COLLISION = 3'd4;
    localparam t_kind K_FAILED    = 3'd5;
    localparam t_kind K_OVERFLOW  = 3'd6;

    localparam logic REG_GAP  = 1'b0;
    localparam logic REG_WAIT = 1'b1;

    localparam t_ticks GAP_RESET  = 16'd12;
    localparam t_ticks WAIT_RESET = 16'd20;

endpackage

### design/becm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input commands and result transactions.
interface becm_in_if;
    import becm_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  command;
    t_byte data;

    modport source (output valid, output command, output data, input ready);
    modport sink   (input valid, input command, input data, output ready);
endinterface

interface becm_out_if;
    import becm_pkg::*;

    logic   valid;
    logic   ready;
    t_kind  kind;
    t_byte  byte_value;
    t_count length;
    logic   last;

    modport source (output valid, output kind, output byte_value, output length,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input length,
                    input last, output ready);
endinterface

### design/bus_echo_collision_monitor_unit.sv
`timescale 1ns / 1ps
// Bus echo collision monitor: rx/tx buffers, gap and wait timers, echo compare sequencer.
//
// channel   | dir | handshake        | payload
// ----------+-----+------------------+----------------------------------
// i_in      | in  | valid/ready      | command, data
// o_out     | out | valid/ready      | kind, byte_value, length, last
// apb       | in  | psel/penable     | paddr, pwdata, prdata (pready = 1)
//
// Load, arm, receive, idle tick: taken in S_IDLE, result registered in S_EXEC once o_out
// is free. A tick that ends a message goes to S_EMIT (S_CMP, S_VERDICT first if armed);
// one byte-compare unit walks both buffers one entry per cycle in S_CMP.
// Result emission stalls while o_out is held; i_in is taken only between transactions.
// Reset is synchronous; buffers hold no reset and are read only where written.
module bus_echo_collision_monitor_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    becm_in_if.sink                 i_in,
    becm_out_if.source              o_out,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [becm_pkg::PAW-1:0] paddr,
    input  logic [becm_pkg::PDW-1:0] pwdata,
    output logic [becm_pkg::PDW-1:0] prdata,
    output logic                    pready
);
    import becm_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_CMP     = 3'd2;
    localparam logic [2:0] S_VERDICT = 3'd3;
    localparam logic [2:0] S_EMIT    = 3'd4;

    t_byte  rx_mem [MAX_BYTES];
    t_byte  tx_mem [MAX_BYTES];

    logic [2:0] r_state, n_state;
    t_cmd       r_cmd, n_cmd;
    t_byte      r_data, n_data;
    t_ticks     r_cfg_gap, r_cfg_wait;
    t_count     r_rx_count, n_rx_count;
    t_count     r_tx_loaded, n_tx_loaded;
    t_count     r_tx_active, n_tx_active;
    t_ticks     r_gap_cnt, n_gap_cnt;
    t_ticks     r_wait_cnt, n_wait_cnt;
    logic       r_wait_run, n_wait_run;
    logic       r_ov, n_ov;
    t_byte      r_tx_first, n_tx_first;
    t_count     r_idx, n_idx;
    logic       r_mismatch, n_mismatch;
    t_byte      r_rx_q, r_tx_q;

    logic       r_out_valid;
    t_kind      r_out_kind, n_out_kind;
    t_byte      r_out_byte, n_out_byte;
    t_count     r_out_len, n_out_len;
    logic       r_out_last, n_out_last;

    logic       w_out_load;
    logic       w_slot_free;
    logic       w_rx_we, w_tx_we;
    logic       w_fail, w_gap_end, w_final;
    logic       w_cfg_we;
    t_ticks     w_gap_reload, w_wait_reload;

    assign pready        = 1'b1;
    assign w_cfg_we      = psel && penable && pwrite;
    assign w_slot_free   = !r_out_valid || o_out.ready;
    assign w_gap_reload  = (r_cfg_gap == '0) ? t_ticks'(1) : r_cfg_gap;
    assign w_wait_reload = (r_cfg_wait == '0) ? t_ticks'(1) : r_cfg_wait;

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.kind       = r_out_kind;
    assign o_out.byte_value = r_out_byte;
    assign o_out.length     = r_out_len;
    assign o_out.last       = r_out_last;

    always_comb begin
        unique case (paddr[2])
            REG_GAP:  prdata = {{(PDW-TW){1'b0}}, r_cfg_gap};
            REG_WAIT: prdata = {{(PDW-TW){1'b0}}, r_cfg_wait};
            default:  prdata = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_data      = r_data;
        n_rx_count  = r_rx_count;
        n_tx_loaded = r_tx_loaded;
        n_tx_active = r_tx_active;
        n_gap_cnt   = r_gap_cnt;
        n_wait_cnt  = r_wait_cnt;
        n_wait_run  = r_wait_run;
        n_ov        = r_ov;
        n_tx_first  = r_tx_first;
        n_idx       = r_idx;
        n_mismatch  = r_mismatch;
        n_out_kind  = r_out_kind;
        n_out_byte  = r_out_byte;
        n_out_len   = r_out_len;
        n_out_last  = r_out_last;
        w_out_load  = 1'b0;
        w_rx_we     = 1'b0;
        w_tx_we     = 1'b0;
        w_fail      = r_wait_run && (r_wait_cnt <= t_ticks'(1));
        w_gap_end   = (r_rx_count != '0) && (r_gap_cnt <= t_ticks'(1));
        w_final     = (r_idx == r_rx_count - t_count'(1));

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd   = i_in.command;
                    n_data  = i_in.data;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_slot_free) begin
                    n_out_byte = '0;
                    n_out_len  = '0;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                    unique case (r_cmd)
                        CMD_LOAD: begin
                            w_out_load = 1'b1;
                            if (r_tx_active != '0 || r_tx_loaded >= t_count'(MAX_BYTES)) begin
                                n_out_kind = K_BUSY;
                            end else begin
                                w_tx_we     = 1'b1;
                                n_tx_loaded = r_tx_loaded + t_count'(1);
                                n_out_kind  = K_ACCEPTED;
                                n_out_len   = r_tx_loaded + t_count'(1);
                                if (r_tx_loaded == '0) begin
                                    n_tx_first = r_data;
                                end
                            end
                        end
                        CMD_ARM: begin
                            w_out_load = 1'b1;
                            if (r_rx_count != '0 || r_tx_active != '0 || r_wait_run) begin
                                n_out_kind = K_BUSY;
                            end else begin
                                n_tx_active = r_tx_loaded;
                                n_tx_loaded = '0;
                                n_out_kind  = K_ACCEPTED;
                                n_out_len   = r_tx_loaded;
                            end
                        end
                        CMD_RX: begin
                            w_out_load = 1'b1;
                            n_gap_cnt  = w_gap_reload;
                            if (r_rx_count >= t_count'(MAX_BYTES)) begin
                                n_ov       = 1'b1;
                                n_out_kind = K_OVERFLOW;
                            end else begin
                                w_rx_we    = 1'b1;
                                n_rx_count = r_rx_count + t_count'(1);
                                if (r_tx_active != '0 && r_rx_count == '0 &&
                                    r_data != r_tx_first) begin
                                    n_wait_cnt  = w_wait_reload;
                                    n_wait_run  = 1'b1;
                                    n_tx_active = '0;
                                    n_out_kind  = K_COLLISION;
                                end else begin
                                    n_out_kind = K_ACCEPTED;
                                    n_out_len  = r_rx_count + t_count'(1);
                                end
                            end
                        end
                        CMD_TICK: begin
                            if (r_wait_run) begin
                                n_wait_cnt = (r_wait_cnt != '0) ? r_wait_cnt - t_ticks'(1) : '0;
                            end
                            if (w_fail) begin
                                n_wait_run = 1'b0;
                                w_out_load = 1'b1;
                                n_out_kind = K_FAILED;
                                n_out_last = !w_gap_end;
                            end
                            if (r_rx_count != '0) begin
                                n_gap_cnt = (r_gap_cnt != '0) ? r_gap_cnt - t_ticks'(1) : '0;
                            end
                            if (w_gap_end) begin
                                n_idx      = '0;
                                n_mismatch = r_ov || (r_rx_count != r_tx_active);
                                n_state    = (r_tx_active != '0) ? S_CMP : S_EMIT;
                            end
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_CMP: begin
                n_mismatch = r_mismatch || (r_rx_q != r_tx_q);
                if (w_final) begin
                    n_idx   = '0;
                    n_state = S_VERDICT;
                end else begin
                    n_idx = r_idx + t_count'(1);
                end
            end
            S_VERDICT: begin
                if (w_slot_free) begin
                    w_out_load  = 1'b1;
                    n_out_byte  = '0;
                    n_out_last  = 1'b0;
                    n_tx_active = '0;
                    if (r_mismatch) begin
                        n_wait_cnt = w_wait_reload;
                        n_wait_run = 1'b1;
                        n_out_kind = K_COLLISION;
                        n_out_len  = '0;
                    end else begin
                        n_out_kind = K_CONFIRMED;
                        n_out_len  = r_rx_count;
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out_kind = K_RXBYTE;
                    n_out_byte = r_rx_q;
                    n_out_len  = r_rx_count;
                    n_out_last = w_final;
                    if (w_final) begin
                        n_rx_count = '0;
                        n_ov       = 1'b0;
                        n_idx      = '0;
                        n_state    = S_IDLE;
                    end else begin
                        n_idx = r_idx + t_count'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rx_we) begin
            rx_mem[r_rx_count[AW-1:0]] <= r_data;
        end
        if (w_tx_we) begin
            tx_mem[r_tx_loaded[AW-1:0]] <= r_data;
        end
        r_rx_q <= rx_mem[n_idx[AW-1:0]];
        r_tx_q <= tx_mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_gap   <= GAP_RESET;
            r_cfg_wait  <= WAIT_RESET;
            r_rx_count  <= '0;
            r_tx_loaded <= '0;
            r_tx_active <= '0;
            r_gap_cnt   <= '0;
            r_wait_cnt  <= '0;
            r_wait_run  <= 1'b0;
            r_ov        <= 1'b0;
            r_idx       <= '0;
            r_mismatch  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rx_count  <= n_rx_count;
            r_tx_loaded <= n_tx_loaded;
            r_tx_active <= n_tx_active;
            r_gap_cnt   <= n_gap_cnt;
            r_wait_cnt  <= n_wait_cnt;
            r_wait_run  <= n_wait_run;
            r_ov        <= n_ov;
            r_idx       <= n_idx;
            r_mismatch  <= n_mismatch;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_we) begin
                unique case (paddr[2])
                    REG_GAP:  r_cfg_gap  <= pwdata[TW-1:0];
                    REG_WAIT: r_cfg_wait <= pwdata[TW-1:0];
                    default:  r_cfg_gap  <= r_cfg_gap;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_data     <= n_data;
        r_tx_first <= n_tx_first;
        if (w_out_load) begin
            r_out_kind <= n_out_kind;
            r_out_byte <= n_out_byte;
            r_out_len  <= n_out_len;
            r_out_last <= n_out_last;
        end
    end

endmodule

### design/becm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the bus echo collision monitor, bound to the top level.
module becm_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    i_in_ready,
    input logic                    i_out_valid,
    input logic                    i_out_ready,
    input logic [2:0]              i_out_kind,
    input logic [becm_pkg::DW-1:0] i_out_byte,
    input logic [becm_pkg::CW-1:0] i_out_len,
    input logic                    i_out_last
);
    import becm_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind) &&
        $stable(i_out_byte) && $stable(i_out_len) && $stable(i_out_last))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken again before the transaction completed");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_kind != 3'd7)
        else $error("undefined result kind");

    a_byte_only_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != K_RXBYTE |-> i_out_byte == '0)
        else $error("byte value set on a non rx byte result");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_len <= t_count'(MAX_BYTES))
        else $error("length beyond buffer size");

endmodule

bind bus_echo_collision_monitor_unit becm_checker u_becm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_byte  (o_out.byte_value),
    .i_out_len   (o_out.length),
    .i_out_last  (o_out.last)
);

### sim/bus_echo_collision_monitor_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bus echo collision monitor: echo exchanges, timers, config.
import becm_pkg::*;

typedef struct packed {
    t_kind  kind;
    t_byte  byte_value;
    t_count length;
    logic   last;
} t_echo_result;

class echo_predictor;
    t_ticks       gap_setting;
    t_ticks       wait_setting;
    t_byte        rx_buf[MAX_BYTES];
    t_byte        tx_buf[MAX_BYTES];
    int           rx_len;
    int           tx_loaded;
    int           armed_len;
    int           gap_left;
    int           wait_left;
    bit           waiting;
    bit           overflowed;
    t_echo_result expected_results[$];
    int           failures;
    int           commands_seen;
    int           results_checked;
    int           kind_tally[7];

    function new();
        gap_setting     = GAP_RESET;
        wait_setting    = WAIT_RESET;
        rx_len          = 0;
        tx_loaded       = 0;
        armed_len       = 0;
        gap_left        = 0;
        wait_left       = 0;
        waiting         = 1'b0;
        overflowed      = 1'b0;
        failures        = 0;
        commands_seen   = 0;
        results_checked = 0;
        foreach (kind_tally[k]) kind_tally[k] = 0;
    endfunction

    function void set_register(logic index, t_ticks value);
        if (index == REG_GAP) begin
            gap_setting = value;
        end else begin
            wait_setting = value;
        end
    endfunction

    function void expect_result(t_kind kind, t_byte value, int len);
        t_echo_result r;
        r.kind       = kind;
        r.byte_value = value;
        r.length     = t_count'(len);
        r.last       = 1'b0;
        expected_results.push_back(r);
    endfunction

    function void begin_collision_wait();
        wait_left = (wait_setting == 0) ? 1 : int'(wait_setting);
        waiting   = 1'b1;
        armed_len = 0;
    endfunction

    function void note_command(t_cmd command, t_byte data);
        int queued;
        int i;
        bit same;
        queued = expected_results.size();
        commands_seen++;
        case (command)
            CMD_LOAD: begin
                if (armed_len > 0 || tx_loaded >= MAX_BYTES) begin
                    expect_result(K_BUSY, '0, 0);
                end else begin
                    tx_buf[tx_loaded] = data;
                    tx_loaded++;
                    expect_result(K_ACCEPTED, '0, tx_loaded);
                end
            end
            CMD_ARM: begin
                if (rx_len > 0 || armed_len > 0 || waiting) begin
                    expect_result(K_BUSY, '0, 0);
                end else begin
                    armed_len = tx_loaded;
                    tx_loaded = 0;
                    expect_result(K_ACCEPTED, '0, armed_len);
                end
            end
            CMD_RX: begin
                gap_left = (gap_setting == 0) ? 1 : int'(gap_setting);
                if (rx_len >= MAX_BYTES) begin
                    overflowed = 1'b1;
                    expect_result(K_OVERFLOW, '0, 0);
                end else begin
                    rx_buf[rx_len] = data;
                    rx_len++;
                    if (armed_len > 0 && rx_len == 1 && data != tx_buf[0]) begin
                        begin_collision_wait();
                        expect_result(K_COLLISION, '0, 0);
                    end else begin
                        expect_result(K_ACCEPTED, '0, rx_len);
                    end
                end
            end
            CMD_TICK: begin
                if (waiting) begin
                    if (wait_left > 0) wait_left--;
                    if (wait_left == 0) begin
                        waiting = 1'b0;
                        expect_result(K_FAILED, '0, 0);
                    end
                end
                if (rx_len > 0) begin
                    if (gap_left > 0) gap_left--;
                    if (gap_left == 0) begin
                        if (armed_len > 0) begin
                            same = !overflowed && rx_len == armed_len;
                            for (i = 0; i < rx_len; i++) begin
                                if (rx_buf[i] != tx_buf[i]) same = 1'b0;
                            end
                            if (same) begin
                                expect_result(K_CONFIRMED, '0, rx_len);
                                armed_len = 0;
                            end else begin
                                begin_collision_wait();
                                expect_result(K_COLLISION, '0, 0);
                            end
                        end
                        for (i = 0; i < rx_len; i++) expect_result(K_RXBYTE, rx_buf[i], rx_len);
                        rx_len     = 0;
                        overflowed = 1'b0;
                    end
                end
            end
        endcase
        if (expected_results.size() > queued) begin
            expected_results[expected_results.size() - 1].last = 1'b1;
        end
    endfunction

    function void check_result(t_kind kind, t_byte value, t_count len, logic last);
        t_echo_result want;
        results_checked++;
        if (kind <= K_OVERFLOW) kind_tally[kind]++;
        if (expected_results.size() == 0) begin
            failures++;
            $display("%0t: unexpected result kind %0d byte %02h length %0d last %0b",
                     $time, kind, value, len, last);
            return;
        end
        want = expected_results.pop_front();
        if (kind !== want.kind || value !== want.byte_value || len !== want.length ||
            last !== want.last) begin
            failures++;
            $display("%0t: kind/byte/len/last expected %0d/%02h/%0d/%0b actual %0d/%02h/%0d/%0b",
                     $time, want.kind, want.byte_value, want.length, want.last,
                     kind, value, len, last);
        end
    endfunction
endclass

module bus_echo_collision_monitor_unit_tb;
    localparam int SETTLE_CYCLES    = 80;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef enum int {
        EX_CLEAN,
        EX_FIRST_BAD,
        EX_LATER_BAD,
        EX_ODD_LENGTH,
        EX_OVERRUN,
        EX_UNARMED,
        EX_NOISY
    } t_exchange_kind;

    logic           i_clk;
    logic           i_rst_n;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [PAW-1:0] paddr;
    logic [PDW-1:0] pwdata;
    logic [PDW-1:0] prdata;
    logic           pready;

    becm_in_if  cmd_bus ();
    becm_out_if result_bus ();

    echo_predictor echo_model;
    bit            idling_on;
    bit            hold_off_request;

    bus_echo_collision_monitor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_bus),
        .o_out   (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin : watchdog
        #40_000_000;
        $display("bus_echo_collision_monitor_unit regression: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            echo_model.check_result(result_bus.kind, result_bus.byte_value,
                                    result_bus.length, result_bus.last);
        end
    end

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall_left       = LONG_HOLD_CYCLES;
            end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
            if (stall_left > 0) begin
                result_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    task automatic send_command(t_cmd command, t_byte data);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= command;
        cmd_bus.data    <= data;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        echo_model.note_command(command, data);
    endtask

    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        while (echo_model.expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic index, t_ticks value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= PDW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        echo_model.set_register(index, value);
    endtask

    task automatic set_timers(t_ticks gap_value, t_ticks wait_value);
        write_register(REG_GAP, gap_value);
        write_register(REG_WAIT, wait_value);
    endtask

    task automatic play_exchange(t_exchange_kind flavor, int msg_len);
        t_byte echo_bytes[MAX_BYTES + 4];
        int    echo_len;
        int    flip_at;
        int    gap_eff;
        int    i;
        for (i = 0; i < msg_len; i++) begin
            echo_bytes[i] = t_byte'($urandom);
            send_command(CMD_LOAD, echo_bytes[i]);
        end
        if (flavor == EX_OVERRUN && msg_len == MAX_BYTES) begin
            send_command(CMD_LOAD, t_byte'($urandom));
        end
        if (flavor != EX_UNARMED) send_command(CMD_ARM, t_byte'($urandom));
        case (flavor)
            EX_ODD_LENGTH: echo_len = $urandom_range(1, 8);
            EX_OVERRUN:    echo_len = MAX_BYTES + $urandom_range(1, 3);
            EX_UNARMED:    echo_len = $urandom_range(1, 8);
            default:       echo_len = (msg_len == 0) ? 1 : msg_len;
        endcase
        for (i = msg_len; i < echo_len; i++) echo_bytes[i] = t_byte'($urandom);
        if (flavor == EX_FIRST_BAD || flavor == EX_LATER_BAD) begin
            flip_at = (flavor == EX_FIRST_BAD || echo_len == 1) ? 0 :
                      $urandom_range(1, echo_len - 1);
            echo_bytes[flip_at] = echo_bytes[flip_at] ^ t_byte'(1 << $urandom_range(0, 7));
        end
        gap_eff = (echo_model.gap_setting == 0) ? 1 : int'(echo_model.gap_setting);
        for (i = 0; i < echo_len; i++) begin
            send_command(CMD_RX, echo_bytes[i]);
            if (flavor == EX_NOISY && $urandom_range(0, 1) == 0) begin
                send_command(($urandom_range(0, 1) == 0) ? CMD_LOAD : CMD_ARM, t_byte'($urandom));
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(0, gap_eff - 1)) begin
                    send_command(CMD_TICK, t_byte'($urandom));
                end
            end
        end
        while (echo_model.rx_len > 0 || echo_model.waiting) begin
            send_command(CMD_TICK, t_byte'($urandom));
        end
        if ($urandom_range(0, 3) == 0) send_command(CMD_TICK, t_byte'($urandom));
    endtask

    initial begin : stimulus
        int             phase;
        int             phase_end;
        int             msg_len;
        t_exchange_kind flavor;

        echo_model       = new();
        idling_on        = 1'b0;
        hold_off_request = 1'b0;
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        cmd_bus.valid   <= 1'b0;
        cmd_bus.command <= CMD_TICK;
        cmd_bus.data    <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_command(CMD_TICK, 8'hFF);
        send_command(CMD_ARM, 8'h00);
        send_command(CMD_LOAD, 8'h00);
        send_command(CMD_LOAD, 8'hFF);
        send_command(CMD_ARM, 8'hFF);
        send_command(CMD_LOAD, 8'h5A);
        send_command(CMD_ARM, 8'h00);
        send_command(CMD_RX, 8'h00);
        send_command(CMD_ARM, 8'h00);
        send_command(CMD_RX, 8'hFF);
        repeat (12) send_command(CMD_TICK, 8'h00);
        drain_results();

        // overrun the receive store behind a full armed message
        idling_on = 1'b1;
        set_timers(16'd2, 16'd3);
        play_exchange(EX_OVERRUN, MAX_BYTES);

        for (phase = 0; phase < 5; phase++) begin
            drain_results();
            case (phase)
                0: set_timers(16'd0, 16'd0);
                1: set_timers(16'd1, 16'd1);
                2: set_timers(16'd4, 16'd4);
                3: set_timers(16'd3, 16'd7);
                default: begin
                    set_timers(t_ticks'($urandom_range(2, 6)),
                               t_ticks'($urandom_range(1, 9)));
                end
            endcase
            if (phase == 2) hold_off_request = 1'b1;
            phase_end = echo_model.commands_seen + 6;
            while (echo_model.commands_seen < phase_end) begin
                idling_on = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 9))
                    4:       flavor = EX_FIRST_BAD;
                    5:       flavor = EX_LATER_BAD;
                    6:       flavor = EX_ODD_LENGTH;
                    8:       flavor = EX_UNARMED;
                    9:       flavor = EX_NOISY;
                    default: flavor = EX_CLEAN;
                endcase
                msg_len = (flavor == EX_UNARMED) ? 0 : $urandom_range(1, 5);
                play_exchange(flavor, msg_len);
                if ($urandom_range(0, 5) == 0) drain_results();
            end
        end

        // equal timers; wait expiry and message end land on one tick
        drain_results();
        idling_on = 1'b0;
        set_timers(16'd5, 16'd5);
        send_command(CMD_LOAD, 8'h3C);
        send_command(CMD_ARM, 8'h00);
        send_command(CMD_RX, 8'hC3);
        while (echo_model.rx_len > 0 || echo_model.waiting) send_command(CMD_TICK, 8'h00);
        drain_results();

        $display("Covered %0d commands and %0d results under default, zero, low and mid timers.",
                 echo_model.commands_seen, echo_model.results_checked);
        $display("Seen %0d confirmed, %0d collisions, %0d failed, %0d overflows, %0d busy.",
                 echo_model.kind_tally[K_CONFIRMED], echo_model.kind_tally[K_COLLISION],
                 echo_model.kind_tally[K_FAILED], echo_model.kind_tally[K_OVERFLOW],
                 echo_model.kind_tally[K_BUSY]);
        if (echo_model.failures == 0 && echo_model.expected_results.size() == 0) begin
            $display("bus_echo_collision_monitor_unit regression: pass");
        end else begin
            $display("bus_echo_collision_monitor_unit regression: fail");
        end
        $finish;
    end
endmodule
